// ----- sv/delay_line_pitch_harmonizer_macros.svh -----
// Assertion macros shared by the harmonizer RTL.
`ifndef DELAY_LINE_PITCH_HARMONIZER_MACROS_SVH
`define DELAY_LINE_PITCH_HARMONIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DLPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dlph_pkg.sv -----
// Types, constants and register codes of the delay line pitch harmonizer.
package dlph_pkg;

  localparam int unsigned BufferDepth = 8192;
  localparam int unsigned SampleBits  = 24;

  localparam int unsigned CfgIdxBits  = 4;
  localparam int unsigned CfgDataBits = 17;
  localparam int unsigned MixBits     = 17;
  localparam int unsigned LevelBits   = 16;
  localparam int unsigned DelayBits   = 13;
  localparam int unsigned OffBits     = 30;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned StepBits    = 16;

  localparam int unsigned BoundShift  = 15;
  localparam int unsigned HarmShift   = 18;
  localparam int unsigned MixPreShift = 4;
  localparam int unsigned DryShift    = 10;
  localparam int unsigned OutShift    = 26;

  localparam logic [StepBits-1:0] StepMajor3 = 16'd17034;
  localparam logic [StepBits-1:0] StepMinor3 = 16'd12400;
  localparam logic [StepBits-1:0] StepFifth  = 16'd32657;

  localparam logic [MixBits-1:0]   MixUnity   = 17'd65536;
  localparam logic [MixBits-1:0]   MixReset   = 17'd32768;
  localparam logic [LevelBits-1:0] LevelReset = 16'd16384;
  localparam logic [DelayBits-1:0] DelayReset = 13'd2400;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_MINOR_THIRD = 4'd0,
    REG_MIX_AMOUNT  = 4'd1,
    REG_HARM_LEVEL  = 4'd2,
    REG_BASE_DELAY  = 4'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_RDB,
    ST_MUL,
    ST_ACC,
    ST_WET1,
    ST_WET2,
    ST_OUT
  } seq_state_e;

  typedef struct packed {
    logic                clr;
    logic                load_a;
    logic                mul;
    logic                acc;
    logic                wet1;
    logic                wet2;
    logic                fin;
    logic [FracBits-1:0] frac;
  } mix_ctl_t;

endpackage

// ----- sv/dlph_if.sv -----
// Handshake interfaces: input frame, output frame and register write channel.
interface dlph_in_if #(
  parameter int unsigned SAMPLE_BITS = dlph_pkg::SampleBits
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface dlph_out_if #(
  parameter int unsigned SAMPLE_BITS = dlph_pkg::SampleBits
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface dlph_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dlph_pkg::CfgIdxBits-1:0]  index;
  logic [dlph_pkg::CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/dlph_store.sv -----
// Stereo delay store: one write and one registered read per cycle, fill tracking.
`include "delay_line_pitch_harmonizer_macros.svh"

module dlph_store #(
  parameter int unsigned DEPTH  = dlph_pkg::BufferDepth,
  parameter int unsigned DATA_W = 2 * dlph_pkg::SampleBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [AW-1:0]     last_q;
  logic              full_q;
  logic              ok_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      last_q <= waddr_i;
    end
  end

  // entries beyond the first pass of writes read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      ok_q   <= 1'b0;
    end else begin
      if (we_i && (waddr_i == LastAddr)) begin
        full_q <= 1'b1;
      end
      ok_q <= full_q || (raddr_i <= last_q);
    end
  end

  assign rdata_o = ok_q ? rdata_q : '0;

  `DLPH_ASSERT_NEXT(a_full_sticky, clk_i, rst_ni, full_q, full_q, "fill flag dropped")

endmodule

// ----- sv/dlph_seq.sv -----
// Sequencer: write and read addressing, voice offsets and step control.
`include "delay_line_pitch_harmonizer_macros.svh"

module dlph_seq #(
  parameter int unsigned BUFFER_DEPTH = dlph_pkg::BufferDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             out_free_i,
  input  logic                             minor_third_i,
  input  logic [dlph_pkg::DelayBits-1:0]   base_delay_i,
  output logic                             we_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0]  waddr_o,
  output logic [$clog2(BUFFER_DEPTH)-1:0]  raddr_o,
  output dlph_pkg::mix_ctl_t               ctl_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned DW = dlph_pkg::DelayBits;
  localparam int unsigned IW = ((AW > DW) ? AW : DW) + 3;
  localparam int unsigned OB = dlph_pkg::OffBits;
  localparam int unsigned OW = OB + 1;
  localparam logic signed [IW-1:0] DepthS = IW'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(BUFFER_DEPTH - 1);

  dlph_pkg::seq_state_e state_q, state_d;
  logic [AW-1:0]        wi_q;
  logic                 voice_q;
  logic signed [IW-1:0] idx_q, idx_d;
  logic signed [OB-1:0] third_q, fifth_q;
  logic signed [OB-1:0] off_sel;
  logic signed [IW-1:0] idx_calc;
  logic                 accept;
  logic                 idx_lo, idx_hi, in_range;
  logic [AW-1:0]        i1, i2;
  logic [dlph_pkg::StepBits-1:0] third_step;

  function automatic logic signed [OB-1:0] advance(
    input logic signed [OB-1:0]             off,
    input logic [dlph_pkg::StepBits-1:0]    step,
    input logic [DW-1:0]                    bd
  );
    logic signed [OW-1:0] s;
    logic signed [OW-1:0] bound;
    s     = OW'(off) + OW'(signed'({1'b0, step}));
    bound = OW'(signed'({1'b0, bd, {dlph_pkg::BoundShift{1'b0}}}));
    priority if (s > bound) begin
      advance = OB'(-bound);
    end else if (s < -bound) begin
      advance = OB'(bound);
    end else begin
      advance = OB'(s);
    end
  endfunction

  assign accept     = in_valid_i && (state_q == dlph_pkg::ST_IDLE);
  assign third_step = minor_third_i ? dlph_pkg::StepMinor3 : dlph_pkg::StepMajor3;

  // read position of a voice: write index - base delay + integer part of offset
  assign off_sel  = (state_q == dlph_pkg::ST_IDLE) ? third_q : fifth_q;
  assign idx_calc = IW'(signed'({1'b0, wi_q})) - IW'(signed'({1'b0, base_delay_i}))
                  + IW'(off_sel >>> dlph_pkg::FracBits);

  assign idx_lo   = idx_q < 0;
  assign idx_hi   = idx_q >= DepthS;
  assign in_range = !idx_lo && !idx_hi;
  assign i1       = idx_q[AW-1:0];
  assign i2       = (i1 == LastAddr) ? '0 : i1 + AW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlph_pkg::ST_IDLE: if (in_valid_i) state_d = dlph_pkg::ST_WRAP;
      dlph_pkg::ST_WRAP: if (in_range) state_d = dlph_pkg::ST_RDB;
      dlph_pkg::ST_RDB:  state_d = dlph_pkg::ST_MUL;
      dlph_pkg::ST_MUL:  state_d = dlph_pkg::ST_ACC;
      dlph_pkg::ST_ACC:  state_d = voice_q ? dlph_pkg::ST_WET1 : dlph_pkg::ST_WRAP;
      dlph_pkg::ST_WET1: state_d = dlph_pkg::ST_WET2;
      dlph_pkg::ST_WET2: state_d = dlph_pkg::ST_OUT;
      dlph_pkg::ST_OUT:  if (out_free_i) state_d = dlph_pkg::ST_IDLE;
      default:           state_d = dlph_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    priority if (accept) begin
      idx_d = idx_calc;
    end else if ((state_q == dlph_pkg::ST_ACC) && !voice_q) begin
      idx_d = idx_calc;
    end else if ((state_q == dlph_pkg::ST_WRAP) && idx_lo) begin
      idx_d = idx_q + DepthS;
    end else if ((state_q == dlph_pkg::ST_WRAP) && idx_hi) begin
      idx_d = idx_q - DepthS;
    end else begin
      idx_d = idx_q;
    end
  end

  always_comb begin
    in_ready_o   = (state_q == dlph_pkg::ST_IDLE);
    we_o         = accept;
    waddr_o      = wi_q;
    raddr_o      = (state_q == dlph_pkg::ST_RDB) ? i2 : i1;
    ctl_o.clr    = accept;
    ctl_o.load_a = (state_q == dlph_pkg::ST_RDB);
    ctl_o.mul    = (state_q == dlph_pkg::ST_MUL);
    ctl_o.acc    = (state_q == dlph_pkg::ST_ACC);
    ctl_o.wet1   = (state_q == dlph_pkg::ST_WET1);
    ctl_o.wet2   = (state_q == dlph_pkg::ST_WET2);
    ctl_o.fin    = (state_q == dlph_pkg::ST_OUT) && out_free_i;
    ctl_o.frac   = voice_q ? fifth_q[dlph_pkg::FracBits-1:0]
                           : third_q[dlph_pkg::FracBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dlph_pkg::ST_IDLE;
      wi_q    <= '0;
      voice_q <= 1'b0;
      idx_q   <= '0;
      third_q <= '0;
      fifth_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (accept) begin
        voice_q <= 1'b0;
      end else if (state_q == dlph_pkg::ST_ACC) begin
        voice_q <= 1'b1;
      end
      if ((state_q == dlph_pkg::ST_OUT) && out_free_i) begin
        third_q <= advance(third_q, third_step, base_delay_i);
        fifth_q <= advance(fifth_q, dlph_pkg::StepFifth, base_delay_i);
        wi_q    <= (wi_q == LastAddr) ? '0 : wi_q + AW'(1);
      end
    end
  end

  `DLPH_ASSERT_NEXT(a_wi_hold, clk_i, rst_ni, (state_q != dlph_pkg::ST_IDLE && state_q != dlph_pkg::ST_OUT), $stable(wi_q), "write index moved mid-frame")
  `DLPH_ASSERT_NOW(a_rd_in_range, clk_i, rst_ni, (state_q == dlph_pkg::ST_RDB), (idx_q >= 0 && idx_q < DepthS), "read position not wrapped")

endmodule

// ----- sv/dlph_mix.sv -----
// Interpolation accumulator, wet/dry mix, saturation and output register.
`include "delay_line_pitch_harmonizer_macros.svh"

module dlph_mix #(
  parameter int unsigned SAMPLE_BITS = dlph_pkg::SampleBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dlph_pkg::mix_ctl_t                 ctl_i,
  input  logic [2*SAMPLE_BITS-1:0]           rdata_i,
  input  logic signed [SAMPLE_BITS-1:0]      left_i,
  input  logic signed [SAMPLE_BITS-1:0]      right_i,
  input  logic [dlph_pkg::MixBits-1:0]       mix_i,
  input  logic [dlph_pkg::LevelBits-1:0]     level_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_free_o,
  output logic signed [SAMPLE_BITS-1:0]      left_o,
  output logic signed [SAMPLE_BITS-1:0]      right_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned PW = SB + 18;
  localparam int unsigned WW = SB + 31;
  localparam int unsigned MW = dlph_pkg::MixBits + 1;
  localparam int unsigned LW = dlph_pkg::LevelBits + 1;
  localparam int unsigned FW = dlph_pkg::FracBits + 1;
  localparam logic signed [WW-1:0] YHi = WW'(signed'({1'b0, {(SB-1){1'b1}}}));
  localparam logic signed [WW-1:0] YLo = WW'(signed'({1'b1, {(SB-1){1'b0}}}));

  logic signed [SB-1:0] x_q [2];
  logic signed [SB-1:0] a_q [2];
  logic signed [PW-1:0] prod_q [2];
  logic signed [PW-1:0] dry_q [2];
  logic signed [PW-1:0] acc_q;
  logic signed [PW-1:0] hm_q;
  logic signed [WW-1:0] wet_q;
  logic signed [SB-1:0] out_q [2];
  logic                 out_valid_q;

  logic signed [SB-1:0] rd [2];
  logic signed [SB:0]   diff [2];
  logic signed [FW-1:0] frs;
  logic signed [SB-1:0] h;
  logic [dlph_pkg::MixBits-1:0] mix_sat, inv;
  logic signed [MW-1:0] mixs, invs;
  logic signed [WW-1:0] sum [2];
  logic signed [WW-1:0] y [2];
  logic signed [SB-1:0] ysat [2];

  assign rd[0]   = signed'(rdata_i[SB-1:0]);
  assign rd[1]   = signed'(rdata_i[2*SB-1:SB]);
  assign frs     = signed'({1'b0, ctl_i.frac});
  assign h       = acc_q[PW-1:dlph_pkg::HarmShift];
  assign mix_sat = (mix_i > dlph_pkg::MixUnity) ? dlph_pkg::MixUnity : mix_i;
  assign inv     = dlph_pkg::MixUnity - mix_sat;
  assign mixs    = signed'({1'b0, mix_sat});
  assign invs    = signed'({1'b0, inv});

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      diff[c] = (SB+1)'(rd[c]) - (SB+1)'(a_q[c]);
      sum[c]  = (WW'(dry_q[c]) <<< dlph_pkg::DryShift) + wet_q;
      y[c]    = sum[c] >>> dlph_pkg::OutShift;
      priority if (y[c] > YHi) begin
        ysat[c] = YHi[SB-1:0];
      end else if (y[c] < YLo) begin
        ysat[c] = YLo[SB-1:0];
      end else begin
        ysat[c] = y[c][SB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      x_q[0] <= left_i;
      x_q[1] <= right_i;
    end
    if (ctl_i.load_a) begin
      a_q[0] <= rd[0];
      a_q[1] <= rd[1];
    end
    if (ctl_i.mul) begin
      prod_q[0] <= PW'(diff[0]) * PW'(frs);
      prod_q[1] <= PW'(diff[1]) * PW'(frs);
    end
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (ctl_i.acc) begin
      acc_q <= acc_q + (PW'(a_q[0]) <<< dlph_pkg::FracBits)
             + (PW'(a_q[1]) <<< dlph_pkg::FracBits) + prod_q[0] + prod_q[1];
    end
    if (ctl_i.wet1) begin
      hm_q     <= PW'(h) * PW'(mixs);
      dry_q[0] <= PW'(x_q[0]) * PW'(invs);
    end
    if (ctl_i.wet2) begin
      wet_q    <= WW'(hm_q >>> dlph_pkg::MixPreShift) * WW'(signed'({1'b0, level_i}));
      dry_q[1] <= PW'(x_q[1]) * PW'(invs);
    end
    if (ctl_i.fin) begin
      out_q[0] <= ysat[0];
      out_q[1] <= ysat[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_free_o  = !out_valid_q || out_ready_i;
  assign left_o      = out_q[0];
  assign right_o     = out_q[1];

  `DLPH_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, ctl_i.fin, (!out_valid_q || out_ready_i), "result overwritten before transaction")

endmodule

// ----- sv/delay_line_pitch_harmonizer.sv -----
// Top level of the stereo delay line pitch harmonizer.
//
//   port     dir  role
//   frame_i  in   stereo input frame  (left_in, right_in)
//   frame_o  out  stereo output frame (left_out, right_out), registered
//   cfg_i    in   register write (index, data), always ready
//
// A frame runs from its transaction to the next ready cycle through one store
// write, then per voice two reads of the single read port, interpolation and
// accumulation, then the mix steps WET1, WET2 and OUT. A voice's read position
// gets BUFFER_DEPTH added or removed in its wrap step until it lies in the store.
// No clearing pass after reset: unwritten entries read as zero by fill tracking.
// A result waiting on frame_o stalls only the final step of the next frame.
module delay_line_pitch_harmonizer #(
  parameter int unsigned BUFFER_DEPTH = dlph_pkg::BufferDepth,
  parameter int unsigned SAMPLE_BITS  = dlph_pkg::SampleBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dlph_in_if.sink           frame_i,
  dlph_out_if.source        frame_o,
  dlph_cfg_if.sink          cfg_i
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic                               minor_q;
  logic [dlph_pkg::MixBits-1:0]       mix_q;
  logic [dlph_pkg::LevelBits-1:0]     level_q;
  logic [dlph_pkg::DelayBits-1:0]     delay_q;

  dlph_pkg::mix_ctl_t       ctl;
  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [2*SAMPLE_BITS-1:0] rdata;
  logic                     out_free;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minor_q <= 1'b0;
      mix_q   <= dlph_pkg::MixReset;
      level_q <= dlph_pkg::LevelReset;
      delay_q <= dlph_pkg::DelayReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        dlph_pkg::REG_MINOR_THIRD: minor_q <= cfg_i.data[0];
        dlph_pkg::REG_MIX_AMOUNT:  mix_q   <= cfg_i.data[dlph_pkg::MixBits-1:0];
        dlph_pkg::REG_HARM_LEVEL:  level_q <= cfg_i.data[dlph_pkg::LevelBits-1:0];
        dlph_pkg::REG_BASE_DELAY:  delay_q <= cfg_i.data[dlph_pkg::DelayBits-1:0];
        default: ;
      endcase
    end
  end

  dlph_seq #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (frame_i.valid),
    .in_ready_o    (frame_i.ready),
    .out_free_i    (out_free),
    .minor_third_i (minor_q),
    .base_delay_i  (delay_q),
    .we_o          (we),
    .waddr_o       (waddr),
    .raddr_o       (raddr),
    .ctl_o         (ctl)
  );

  dlph_store #(
    .DEPTH  (BUFFER_DEPTH),
    .DATA_W (2 * SAMPLE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({frame_i.right_in, frame_i.left_in}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  dlph_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .rdata_i     (rdata),
    .left_i      (frame_i.left_in),
    .right_i     (frame_i.right_in),
    .mix_i       (mix_q),
    .level_i     (level_q),
    .out_ready_i (frame_o.ready),
    .out_valid_o (frame_o.valid),
    .out_free_o  (out_free),
    .left_o      (frame_o.left_out),
    .right_o     (frame_o.right_out)
  );

endmodule
